>>> hw/rtl/pbb_pkg.sv
package pbb_pkg;

  // Field widths
  localparam int unsigned CoordW  = 32;
  localparam int unsigned SizeW   = 31;
  localparam int unsigned MatW    = 16;
  localparam int unsigned RowW    = 3 * MatW;
  localparam int unsigned AbsW    = 16;
  localparam int unsigned ProdW   = AbsW + SizeW;
  localparam int unsigned SumW    = ProdW + 2;
  localparam int unsigned RoundSh = 15;
  localparam int unsigned ExtW    = SumW - RoundSh;
  localparam int unsigned WideW   = ExtW + 2;

  localparam logic [SumW-1:0] RoundAdd = SumW'((1 << RoundSh) - 1);

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [SizeW-1:0]         size_t;
  typedef logic [RowW-1:0]          row_t;
  typedef logic [AbsW-1:0]          mag_t;
  typedef logic [ProdW-1:0]         prod_t;
  typedef logic [ExtW-1:0]          ext_t;

  // Per-stage load enables, derived from the valid bits and the output stall
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
  } pipe_ctl_t;

  // Magnitude of a signed Q2.14 entry (the most negative code gives 2.0)
  function automatic mag_t abs_q214(input logic [MatW-1:0] v);
    logic [MatW:0] neg;
    neg = (MatW+1)'(1 << MatW) - {1'b0, v};
    return v[MatW-1] ? neg[AbsW-1:0] : v;
  endfunction

  // Clamp a wide signed value to the signed 32-bit range
  function automatic coord_t sat_coord(input logic signed [WideW-1:0] v);
    logic fits;
    fits = (&v[WideW-1:CoordW-1]) || !(|v[WideW-1:CoordW-1]);
    if (fits) begin
      return v[CoordW-1:0];
    end else if (v[WideW-1]) begin
      return {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      return {1'b0, {(CoordW-1){1'b1}}};
    end
  endfunction

endpackage

>>> hw/rtl/pbb_axis_ext.sv
module pbb_axis_ext (
  input  logic                clk_i,
  input  pbb_pkg::pipe_ctl_t  ctl_i,
  input  logic                mode_i,
  input  pbb_pkg::size_t      radius_i,
  input  pbb_pkg::size_t      size_x_i,
  input  pbb_pkg::size_t      size_y_i,
  input  pbb_pkg::size_t      size_z_i,
  input  pbb_pkg::row_t       row_i,
  output pbb_pkg::ext_t       ext_o
);

  pbb_pkg::mag_t  mag_q  [3];
  pbb_pkg::size_t size_q [3];
  pbb_pkg::prod_t prod_q [3];
  logic           mode1_q, mode2_q;
  pbb_pkg::size_t rad1_q, rad2_q;
  pbb_pkg::ext_t  ext_q, ext_d;

  logic [pbb_pkg::SumW-1:0] sum;

  // Stage 1: take entry magnitudes, hold extents
  always_ff @(posedge clk_i) begin
    if (ctl_i.en1) begin
      for (int j = 0; j < 3; j++) begin
        mag_q[j] <= pbb_pkg::abs_q214(row_i[j*pbb_pkg::MatW +: pbb_pkg::MatW]);
      end
      size_q[0] <= size_x_i;
      size_q[1] <= size_y_i;
      size_q[2] <= size_z_i;
      mode1_q   <= mode_i;
      rad1_q    <= radius_i;
    end
  end

  // Stage 2: one 16x31 product per matrix column
  always_ff @(posedge clk_i) begin
    if (ctl_i.en2) begin
      for (int j = 0; j < 3; j++) begin
        prod_q[j] <= pbb_pkg::ProdW'(mag_q[j]) * pbb_pkg::ProdW'(size_q[j]);
      end
      mode2_q <= mode1_q;
      rad2_q  <= rad1_q;
    end
  end

  // Stage 3: sum, round up to Q16.16, pick sphere radius or box extent
  always_comb begin
    sum = pbb_pkg::SumW'(prod_q[0]) + pbb_pkg::SumW'(prod_q[1])
        + pbb_pkg::SumW'(prod_q[2]) + pbb_pkg::RoundAdd;
    ext_d = mode2_q ? sum[pbb_pkg::SumW-1:pbb_pkg::RoundSh] : pbb_pkg::ExtW'(rad2_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en3) begin
      ext_q <= ext_d;
    end
  end

  assign ext_o = ext_q;

endmodule

>>> hw/rtl/pbb_bound.sv
module pbb_bound (
  input  logic               clk_i,
  input  pbb_pkg::pipe_ctl_t ctl_i,
  input  pbb_pkg::coord_t    pos_i,
  input  pbb_pkg::ext_t      ext_i,
  output pbb_pkg::coord_t    min_o,
  output pbb_pkg::coord_t    max_o
);

  logic signed [pbb_pkg::WideW-1:0] pos_w, ext_w, lo, hi;
  pbb_pkg::coord_t min_q, min_d, max_q, max_d;

  // Widen, offset by the extent, clamp
  always_comb begin
    pos_w = {{(pbb_pkg::WideW-pbb_pkg::CoordW){pos_i[pbb_pkg::CoordW-1]}}, pos_i};
    ext_w = {{(pbb_pkg::WideW-pbb_pkg::ExtW){1'b0}}, ext_i};
    lo    = pos_w - ext_w;
    hi    = pos_w + ext_w;
    min_d = pbb_pkg::sat_coord(lo);
    max_d = pbb_pkg::sat_coord(hi);
  end

  // Stage 4: output register
  always_ff @(posedge clk_i) begin
    if (ctl_i.en4) begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  assign min_o = min_q;
  assign max_o = max_q;

endmodule

>>> hw/rtl/primitive_bounding_box_unit.sv
// Axis-aligned bounding box of one sphere or oriented box per transaction.
// An accepted transaction reaches out_valid_o through the stage registers v1_q, v2_q, v3_q and v4_q.
// Throughput: one transaction per cycle while the output is not stalled; bubbles collapse while the output stalls.
// Stages: entry magnitude, 16x31 products, sum and round-up, offset and clamp.
// Reset (rst_ni low, asynchronous) clears the stage valid bits only.
module primitive_bounding_box_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        mode_i,
  input  logic signed [31:0]          pos_x_i,
  input  logic signed [31:0]          pos_y_i,
  input  logic signed [31:0]          pos_z_i,
  input  logic [30:0]                 radius_i,
  input  logic [30:0]                 size_x_i,
  input  logic [30:0]                 size_y_i,
  input  logic [30:0]                 size_z_i,
  input  logic [47:0]                 rot_row0_i,
  input  logic [47:0]                 rot_row1_i,
  input  logic [47:0]                 rot_row2_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [31:0]          min_x_o,
  output logic signed [31:0]          min_y_o,
  output logic signed [31:0]          min_z_o,
  output logic signed [31:0]          max_x_o,
  output logic signed [31:0]          max_y_o,
  output logic signed [31:0]          max_z_o
);

  pbb_pkg::pipe_ctl_t ctl;
  logic v1_q, v2_q, v3_q, v4_q;

  pbb_pkg::coord_t pos_in [3];
  pbb_pkg::coord_t pos1_q [3];
  pbb_pkg::coord_t pos2_q [3];
  pbb_pkg::coord_t pos3_q [3];
  pbb_pkg::row_t   rows   [3];
  pbb_pkg::ext_t   ext    [3];
  pbb_pkg::coord_t mins   [3];
  pbb_pkg::coord_t maxs   [3];

  assign pos_in[0] = pos_x_i;
  assign pos_in[1] = pos_y_i;
  assign pos_in[2] = pos_z_i;
  assign rows[0]   = rot_row0_i;
  assign rows[1]   = rot_row1_i;
  assign rows[2]   = rot_row2_i;

  // Load a stage when it is empty or the next one moves
  always_comb begin
    ctl.en4 = !v4_q || !out_stall_i;
    ctl.en3 = !v3_q || ctl.en4;
    ctl.en2 = !v2_q || ctl.en3;
    ctl.en1 = !v1_q || ctl.en2;
  end

  assign in_stall_o = !ctl.en1;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (ctl.en1) v1_q <= in_valid_i;
      if (ctl.en2) v2_q <= v1_q;
      if (ctl.en3) v3_q <= v2_q;
      if (ctl.en4) v4_q <= v3_q;
    end
  end

  // Carry the center alongside the extent computation
  always_ff @(posedge clk_i) begin
    if (ctl.en1) pos1_q <= pos_in;
    if (ctl.en2) pos2_q <= pos1_q;
    if (ctl.en3) pos3_q <= pos2_q;
  end

  for (genvar c = 0; c < 3; c++) begin : g_axis
    pbb_axis_ext u_ext (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .mode_i   (mode_i),
      .radius_i (radius_i),
      .size_x_i (size_x_i),
      .size_y_i (size_y_i),
      .size_z_i (size_z_i),
      .row_i    (rows[c]),
      .ext_o    (ext[c])
    );

    pbb_bound u_bound (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .pos_i (pos3_q[c]),
      .ext_i (ext[c]),
      .min_o (mins[c]),
      .max_o (maxs[c])
    );
  end

  assign out_valid_o = v4_q;
  assign min_x_o     = mins[0];
  assign min_y_o     = mins[1];
  assign min_z_o     = mins[2];
  assign max_x_o     = maxs[0];
  assign max_y_o     = maxs[1];
  assign max_z_o     = maxs[2];

endmodule

>>> hw/rtl/pbb_checker.sv
module pbb_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic               mode_i,
  input  logic signed [31:0] pos_x_i,
  input  logic [30:0]        radius_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic signed [31:0] min_x_o,
  input  logic signed [31:0] min_y_o,
  input  logic signed [31:0] min_z_o,
  input  logic signed [31:0] max_x_o,
  input  logic signed [31:0] max_y_o,
  input  logic signed [31:0] max_z_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(min_x_o) && $stable(max_z_o))
    else $error("stalled result changed");

  // With the output free, a transaction appears after four stages
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
    |=> out_valid_o)
    else $error("result missing after pipeline latency");

  // A zero-radius sphere collapses to its center
  a_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !mode_i && radius_i == 31'd0)
    ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
    |=> out_valid_o && min_x_o == $past(pos_x_i, 4) && max_x_o == $past(pos_x_i, 4))
    else $error("zero-radius sphere not at its center");

  // Lower bounds never exceed upper bounds
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> min_x_o <= max_x_o && min_y_o <= max_y_o && min_z_o <= max_z_o)
    else $error("inverted bounding box");

endmodule

bind primitive_bounding_box_unit pbb_checker u_pbb_checker (.*);

>>> dv/testbench.sv
module testbench;

  localparam logic ModeSphere = 1'b0;
  localparam logic ModeBox    = 1'b1;

  localparam pbb_pkg::coord_t CoordMax = 32'sh7FFF_FFFF;
  localparam pbb_pkg::coord_t CoordMin = 32'sh8000_0000;
  localparam pbb_pkg::size_t  LenMax   = 31'h7FFF_FFFF;

  // Q2.14 matrix entries
  localparam logic [15:0] QZero    = 16'h0000;
  localparam logic [15:0] QOne     = 16'h4000;
  localparam logic [15:0] QNegOne  = 16'hC000;
  localparam logic [15:0] QMostPos = 16'h7FFF;
  localparam logic [15:0] QMostNeg = 16'h8000;
  localparam logic [15:0] QNegTiny = 16'hFFFF;

  localparam int unsigned NumRandom = 1300;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned TimeLimit = 10_000_000;

  typedef struct packed {
    logic            mode;
    pbb_pkg::coord_t pos_x;
    pbb_pkg::coord_t pos_y;
    pbb_pkg::coord_t pos_z;
    pbb_pkg::size_t  radius;
    pbb_pkg::size_t  size_x;
    pbb_pkg::size_t  size_y;
    pbb_pkg::size_t  size_z;
    pbb_pkg::row_t   rot0;
    pbb_pkg::row_t   rot1;
    pbb_pkg::row_t   rot2;
  } prim_t;

  typedef struct packed {
    pbb_pkg::coord_t min_x;
    pbb_pkg::coord_t min_y;
    pbb_pkg::coord_t min_z;
    pbb_pkg::coord_t max_x;
    pbb_pkg::coord_t max_y;
    pbb_pkg::coord_t max_z;
  } bbox_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic            mode_i = ModeSphere;
  pbb_pkg::coord_t pos_x_i = '0;
  pbb_pkg::coord_t pos_y_i = '0;
  pbb_pkg::coord_t pos_z_i = '0;
  pbb_pkg::size_t  radius_i = '0;
  pbb_pkg::size_t  size_x_i = '0;
  pbb_pkg::size_t  size_y_i = '0;
  pbb_pkg::size_t  size_z_i = '0;
  pbb_pkg::row_t   rot_row0_i = '0;
  pbb_pkg::row_t   rot_row1_i = '0;
  pbb_pkg::row_t   rot_row2_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  pbb_pkg::coord_t min_x_o;
  pbb_pkg::coord_t min_y_o;
  pbb_pkg::coord_t min_z_o;
  pbb_pkg::coord_t max_x_o;
  pbb_pkg::coord_t max_y_o;
  pbb_pkg::coord_t max_z_o;

  prim_t prims_to_send [$];
  bbox_t boxes_due [$];
  prim_t prim_on_bus;

  int unsigned n_planned = 0;
  int unsigned n_accepted = 0;
  int unsigned n_spheres = 0;
  int unsigned n_boxes = 0;
  int unsigned n_results = 0;
  int unsigned n_clamped = 0;
  int unsigned n_errors = 0;

  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned stall_left = 0;
  int unsigned stall_calm = 0;

  string field_name [6] = '{"min_x", "min_y", "min_z", "max_x", "max_y", "max_z"};

  primitive_bounding_box_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .pos_z_i     (pos_z_i),
    .radius_i    (radius_i),
    .size_x_i    (size_x_i),
    .size_y_i    (size_y_i),
    .size_z_i    (size_z_i),
    .rot_row0_i  (rot_row0_i),
    .rot_row1_i  (rot_row1_i),
    .rot_row2_i  (rot_row2_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .min_x_o     (min_x_o),
    .min_y_o     (min_y_o),
    .min_z_o     (min_z_o),
    .max_x_o     (max_x_o),
    .max_y_o     (max_y_o),
    .max_z_o     (max_z_o)
  );

  // Generate the clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Clamp a wide signed bound to the Q16.16 range
  function automatic pbb_pkg::coord_t clamp_coord(input longint v);
    if (v > longint'(CoordMax)) begin
      return CoordMax;
    end else if (v < longint'(CoordMin)) begin
      return CoordMin;
    end
    return pbb_pkg::coord_t'(v);
  endfunction

  // Compute the expected axis-aligned box of one primitive
  function automatic bbox_t bounding_box(input prim_t p);
    longint          center [3];
    logic [30:0]     extent [3];
    logic [47:0]     row [3];
    logic [63:0]     half_ext [3];
    logic [63:0]     acc;
    logic [63:0]     mag;
    logic [15:0]     entry;
    pbb_pkg::coord_t lo [3];
    pbb_pkg::coord_t hi [3];
    center[0] = longint'(p.pos_x);
    center[1] = longint'(p.pos_y);
    center[2] = longint'(p.pos_z);
    extent[0] = p.size_x;
    extent[1] = p.size_y;
    extent[2] = p.size_z;
    row[0] = p.rot0;
    row[1] = p.rot1;
    row[2] = p.rot2;
    for (int c = 0; c < 3; c++) begin
      if (p.mode == ModeSphere) begin
        half_ext[c] = {33'b0, p.radius};
      end else begin
        // Sum |R[c][j]| * size_j in units of 2^-31, then round up to Q16.16
        acc = '0;
        for (int j = 0; j < 3; j++) begin
          entry = row[c][16*j +: 16];
          mag = entry[15] ? (64'h1_0000 - {48'b0, entry}) : {48'b0, entry};
          acc = acc + mag * {33'b0, extent[j]};
        end
        half_ext[c] = (acc + 64'd32767) >> 15;
      end
      lo[c] = clamp_coord(center[c] - longint'(half_ext[c]));
      hi[c] = clamp_coord(center[c] + longint'(half_ext[c]));
    end
    return {lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]};
  endfunction

  // Pick an idle length: mostly none or short, a few long, with calm stretches
  function automatic int unsigned idle_len(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 6) begin
      calm = $urandom_range(20, 100);
    end
    if (r < 500) return 0;
    if (r < 850) return $urandom_range(1, 3);
    if (r < 980) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  function automatic pbb_pkg::coord_t rand_coord();
    int unsigned r;
    r = $urandom_range(0, 15);
    case (r)
      0: return CoordMax;
      1: return CoordMin;
      2: return '0;
      3, 4, 5: return pbb_pkg::coord_t'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      default: return pbb_pkg::coord_t'($urandom);
    endcase
  endfunction

  function automatic pbb_pkg::size_t rand_len();
    int unsigned r;
    r = $urandom_range(0, 15);
    case (r)
      0: return LenMax;
      1: return '0;
      2, 3, 4, 5, 6: return pbb_pkg::size_t'($urandom_range(0, 1 << 22));
      default: return pbb_pkg::size_t'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_entry();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return QMostNeg;
      1: return QMostPos;
      2: return $urandom_range(0, 1) ? QOne : QNegOne;
      3, 4, 5, 6: return 16'($signed($urandom_range(0, 32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pbb_pkg::row_t rand_row();
    return {rand_entry(), rand_entry(), rand_entry()};
  endfunction

  // Build a sphere; box fields carry noise that the block must ignore
  function automatic prim_t make_sphere(input pbb_pkg::coord_t px, py, pz,
                                        input pbb_pkg::size_t rad);
    return '{mode: ModeSphere, pos_x: px, pos_y: py, pos_z: pz, radius: rad,
             size_x: rand_len(), size_y: rand_len(), size_z: rand_len(),
             rot0: rand_row(), rot1: rand_row(), rot2: rand_row()};
  endfunction

  // Build an oriented box; the radius carries noise
  function automatic prim_t make_box(input pbb_pkg::coord_t px, py, pz,
                                     input pbb_pkg::size_t sx, sy, sz,
                                     input pbb_pkg::row_t r0, r1, r2);
    return '{mode: ModeBox, pos_x: px, pos_y: py, pos_z: pz, radius: rand_len(),
             size_x: sx, size_y: sy, size_z: sz, rot0: r0, rot1: r1, rot2: r2};
  endfunction

  task automatic report_error(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    n_errors++;
  endtask

  // Drive primitives; hold the payload while stalled
  always @(posedge clk_i) begin
    prim_t nxt;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        boxes_due.push_back(bounding_box(prim_on_bus));
        n_accepted++;
        if (prim_on_bus.mode == ModeBox) n_boxes++;
        else n_spheres++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (prims_to_send.size() != 0) begin
          nxt = prims_to_send.pop_front();
          prim_on_bus = nxt;
          mode_i     <= nxt.mode;
          pos_x_i    <= nxt.pos_x;
          pos_y_i    <= nxt.pos_y;
          pos_z_i    <= nxt.pos_z;
          radius_i   <= nxt.radius;
          size_x_i   <= nxt.size_x;
          size_y_i   <= nxt.size_y;
          size_z_i   <= nxt.size_z;
          rot_row0_i <= nxt.rot0;
          rot_row1_i <= nxt.rot1;
          rot_row2_i <= nxt.rot2;
          in_valid_i <= 1'b1;
          send_gap = idle_len(send_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Check results in order and apply random output stall
  always @(posedge clk_i) begin
    bbox_t got;
    bbox_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {min_x_o, min_y_o, min_z_o, max_x_o, max_y_o, max_z_o};
        if (boxes_due.size() == 0) begin
          report_error("result with no primitive outstanding");
        end else begin
          want = boxes_due.pop_front();
          n_results++;
          for (int k = 0; k < 6; k++) begin
            if (got[(5-k)*32 +: 32] !== want[(5-k)*32 +: 32]) begin
              report_error($sformatf("result %0d %s got %h want %h", n_results,
                                     field_name[k], got[(5-k)*32 +: 32],
                                     want[(5-k)*32 +: 32]));
            end
          end
          for (int k = 0; k < 6; k++) begin
            if (want[k*32 +: 32] == CoordMax || want[k*32 +: 32] == CoordMin) begin
              n_clamped++;
              break;
            end
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = idle_len(stall_calm);
      end
    end
  end

  // Fill the stimulus queue, release reset, and wait for the run to drain
  initial begin
    pbb_pkg::row_t ident0;
    pbb_pkg::row_t ident1;
    pbb_pkg::row_t ident2;
    ident0 = {QZero, QZero, QOne};
    ident1 = {QZero, QOne, QZero};
    ident2 = {QOne, QZero, QZero};

    // Spheres: zero, full radius, clamping on both sides
    prims_to_send.push_back(make_sphere('0, '0, '0, '0));
    prims_to_send.push_back(make_sphere('0, '0, '0, LenMax));
    prims_to_send.push_back(make_sphere(CoordMax, CoordMax, CoordMax, LenMax));
    prims_to_send.push_back(make_sphere(CoordMin, CoordMin, CoordMin, LenMax));
    prims_to_send.push_back(make_sphere(CoordMax, CoordMin, '0, '0));
    prims_to_send.push_back(make_sphere(-32'sd1, 32'sd1, 32'sh0001_0000, 31'h0000_8000));

    // Identity boxes: round-up of odd sizes, full sizes, clamping
    prims_to_send.push_back(make_box('0, '0, '0, 31'd1, 31'd2, 31'd3,
                                     ident0, ident1, ident2));
    prims_to_send.push_back(make_box('0, '0, '0, LenMax, LenMax, LenMax,
                                     ident0, ident1, ident2));
    prims_to_send.push_back(make_box(CoordMax, CoordMin, '0, LenMax, LenMax, LenMax,
                                     ident0, ident1, ident2));
    prims_to_send.push_back(make_box(CoordMin, CoordMin, CoordMin, 31'd5, 31'd7, 31'd9,
                                     ident0, ident1, ident2));

    // Extreme and tiny matrix entries, with full or unit sizes
    prims_to_send.push_back(make_box('0, '0, '0, LenMax, LenMax, LenMax,
                                     {3{QMostNeg}}, {3{QMostNeg}}, {3{QMostNeg}}));
    prims_to_send.push_back(make_box('0, '0, '0, LenMax, LenMax, LenMax,
                                     {3{QMostPos}}, {3{QMostPos}}, {3{QMostPos}}));
    prims_to_send.push_back(make_box('0, '0, '0, 31'd1, 31'd1, 31'd1,
                                     {3{QNegTiny}}, {3{QNegTiny}}, {3{QNegTiny}}));
    prims_to_send.push_back(make_box(32'sh0123_4567, '0, '0, LenMax, LenMax, LenMax,
                                     {3{16'h0001}}, {3{16'h0001}}, {3{16'h0001}}));

    // Degenerate: zero matrix, zero sizes
    prims_to_send.push_back(make_box(rand_coord(), rand_coord(), rand_coord(),
                                     LenMax, LenMax, LenMax, '0, '0, '0));
    prims_to_send.push_back(make_box(rand_coord(), rand_coord(), rand_coord(),
                                     '0, '0, '0, rand_row(), rand_row(), rand_row()));

    // Quarter turn about z, negated diagonal, and a shear
    prims_to_send.push_back(make_box(32'sh0010_0000, -32'sh0010_0000, '0,
                                     31'h0002_0000, 31'h0004_0000, 31'h0006_0000,
                                     {QZero, QNegOne, QZero}, {QZero, QZero, QOne},
                                     {QOne, QZero, QZero}));
    prims_to_send.push_back(make_box('0, '0, '0, 31'd3, 31'd5, 31'd7,
                                     {QZero, QZero, QNegOne}, {QZero, QNegOne, QZero},
                                     {QNegOne, QZero, QZero}));
    prims_to_send.push_back(make_box(-32'sd100, 32'sd100, 32'sd7,
                                     31'h0001_0001, 31'h0003_0000, 31'h0000_FFFF,
                                     {QZero, QOne, QOne}, {QNegOne, QOne, QZero},
                                     {QOne, QZero, QMostNeg}));

    // Random primitives, mostly boxes
    for (int n = 0; n < NumRandom; n++) begin
      if ($urandom_range(0, 9) < 4) begin
        prims_to_send.push_back(make_sphere(rand_coord(), rand_coord(), rand_coord(),
                                            rand_len()));
      end else begin
        prims_to_send.push_back(make_box(rand_coord(), rand_coord(), rand_coord(),
                                         rand_len(), rand_len(), rand_len(),
                                         rand_row(), rand_row(), rand_row()));
      end
    end
    n_planned = prims_to_send.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted != n_planned) @(posedge clk_i);
    while (boxes_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d primitives: %0d spheres, %0d oriented boxes", n_accepted,
             n_spheres, n_boxes);
    $display("checked %0d boxes, %0d of them with a clamped bound", n_results, n_clamped);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(TimeLimit);
    $display("timeout waiting for results");
    $display("status: fail");
    $finish;
  end

endmodule
